>>> hw/rtl/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;

   localparam int NumberBits   = 32;
   localparam int WordBits     = 32;
   localparam int RoundsBits   = 6;
   localparam int DataBytes    = (WordBits + 1 + 7) / 8;
   localparam int RspDataBits  = DataBytes * 8;
   localparam logic [WordBits-1:0] NumberMask =
      WordBits'((64'd1 << NumberBits) - 64'd1);
   localparam logic [RoundsBits-1:0] RoundsReset = RoundsBits'(20);
   localparam logic [RoundsBits-1:0] RoundsMax   = RoundsBits'(32);
   localparam logic [WordBits-1:0]   LfsrSeed    = 32'h0000_ACE1;
   localparam logic [WordBits-1:0]   LfsrTaps    = 32'h8020_0003;
   localparam int MulCntBits = $clog2(WordBits);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_ROUND,
      ST_BASE_WAIT,
      ST_POW,
      ST_ACC_MUL,
      ST_SQ_MUL,
      ST_CHECK,
      ST_SQR,
      ST_X_MUL,
      ST_DONE
   } state_type;

   // request to the modular multiplier
   typedef struct packed {
      logic                start;
      logic [WordBits-1:0] a;
      logic [WordBits-1:0] b;
      logic [WordBits-1:0] m;
   } mm_req_type;

   function automatic logic [WordBits-1:0] lfsr_step(input logic [WordBits-1:0] v);
      logic [WordBits-1:0] sh;
      sh = {1'b0, v[WordBits-1:1]};
      return v[0] ? (sh ^ LfsrTaps) : sh;
   endfunction

endpackage

>>> hw/rtl/miller_rabin_prime_test.sv
`timescale 1ns / 1ps
// Flow: numbers below 4 or even settle without rounds and go straight to the result.
//   Odd n >= 5 with n-1 = d * 2^s: split off s, then per round draw a base,
//   raise it to d by square-and-multiply and square at most s-1 times.
// Throughput: one number at a time; the next beat is accepted in the idle state entered as the result loads.
//   The shared modular multiplier sets the pace.
// Reset (synchronous, active high): idle, no result pending, rounds = 20, LFSR = 0xACE1.
module miller_rabin_prime_test (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,  // [31:0] number
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] tested_number, [32] probably_prime, rest zero
   output logic [mrpt_pkg::RspDataBits-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mrpt_pkg::RoundsBits-1:0]      csr_data    // rounds
);

   localparam int W = mrpt_pkg::WordBits;
   localparam int R = mrpt_pkg::RoundsBits;

   mrpt_pkg::state_type   state_ff, state_in;
   mrpt_pkg::mm_req_type  mm_req;
   logic                  mm_done;
   logic [W-1:0]          mm_res;

   logic [R-1:0]  rounds_ff;
   logic [W-1:0]  lfsr_ff, lfsr_nx;
   logic [W-1:0]  n_ff, d_ff, e_ff, acc_ff, sq_ff;
   logic [R-1:0]  s_ff, i_ff, k_ff, r_ff;
   logic          prime_ff;
   logic          rsp_valid_ff;
   logic [mrpt_pkg::RspDataBits-1:0] rsp_data_ff;

   logic [W-1:0]  n_new, n_m1;
   logic          accept, trivial, out_free, round_last;
   logic          chk_pass, x_pass, x_fail;

   assign n_new      = req_tdata & mrpt_pkg::NumberMask;
   assign n_m1       = n_ff - W'(1);
   assign accept     = req_tvalid && req_tready;
   // 0,1,2,3 and even numbers settle without rounds
   assign trivial    = (n_new < W'(4)) || !n_new[0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign round_last = (r_ff + R'(1)) == k_ff;
   assign chk_pass   = (acc_ff == W'(1)) || (acc_ff == n_m1);
   assign x_pass     = mm_done && (mm_res == n_m1);
   assign x_fail     = mm_done && (mm_res == W'(1));
   assign lfsr_nx    = mrpt_pkg::lfsr_step(lfsr_ff);

   // shared modular multiplier
   mrpt_modmul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mm_req),
      .done   (mm_done),
      .result (mm_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrpt_pkg::ST_IDLE:
            if (accept) begin
               state_in = trivial ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_SPLIT;
            end
         mrpt_pkg::ST_SPLIT:
            if (d_ff[0]) begin
               state_in = mrpt_pkg::ST_ROUND;
            end
         mrpt_pkg::ST_ROUND:
            state_in = mrpt_pkg::ST_BASE_WAIT;
         mrpt_pkg::ST_BASE_WAIT:
            if (mm_done) begin
               state_in = mrpt_pkg::ST_POW;
            end
         mrpt_pkg::ST_POW:
            if (e_ff == '0) begin
               state_in = mrpt_pkg::ST_CHECK;
            end else if (e_ff[0]) begin
               state_in = mrpt_pkg::ST_ACC_MUL;
            end else begin
               state_in = mrpt_pkg::ST_SQ_MUL;
            end
         mrpt_pkg::ST_ACC_MUL:
            if (mm_done) begin
               state_in = mrpt_pkg::ST_SQ_MUL;
            end
         mrpt_pkg::ST_SQ_MUL:
            if (mm_done) begin
               state_in = mrpt_pkg::ST_POW;
            end
         mrpt_pkg::ST_CHECK:
            if (chk_pass) begin
               state_in = round_last ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_ROUND;
            end else begin
               state_in = mrpt_pkg::ST_SQR;
            end
         mrpt_pkg::ST_SQR:
            state_in = (i_ff < s_ff) ? mrpt_pkg::ST_X_MUL : mrpt_pkg::ST_DONE;
         mrpt_pkg::ST_X_MUL:
            if (x_pass) begin
               state_in = round_last ? mrpt_pkg::ST_DONE : mrpt_pkg::ST_ROUND;
            end else if (x_fail) begin
               state_in = mrpt_pkg::ST_DONE;
            end else if (mm_done) begin
               state_in = mrpt_pkg::ST_SQR;
            end
         mrpt_pkg::ST_DONE:
            if (out_free) begin
               state_in = mrpt_pkg::ST_IDLE;
            end
         default:
            state_in = mrpt_pkg::ST_IDLE;
      endcase
   end

   // outputs: multiplier requests, handshakes
   always_comb begin
      mm_req.start = 1'b0;
      mm_req.a     = sq_ff;
      mm_req.b     = sq_ff;
      mm_req.m     = n_ff;
      req_tready   = 1'b0;
      case (state_ff)
         mrpt_pkg::ST_IDLE:
            req_tready = 1'b1;
         mrpt_pkg::ST_ROUND: begin
            // r mod (n-4), as a multiply by one
            mm_req.start = 1'b1;
            mm_req.a     = W'(1);
            mm_req.b     = lfsr_nx;
            mm_req.m     = n_ff - W'(4);
         end
         mrpt_pkg::ST_POW:
            if (e_ff != '0) begin
               mm_req.start = 1'b1;
               if (e_ff[0]) begin
                  mm_req.a = acc_ff;
               end
            end
         mrpt_pkg::ST_ACC_MUL:
            mm_req.start = mm_done;
         mrpt_pkg::ST_SQR: begin
            mm_req.start = i_ff < s_ff;
            mm_req.a     = acc_ff;
            mm_req.b     = acc_ff;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrpt_pkg::ST_IDLE;
         rounds_ff    <= mrpt_pkg::RoundsReset;
         lfsr_ff      <= mrpt_pkg::LfsrSeed;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            rounds_ff <= csr_data;
         end
         if (state_ff == mrpt_pkg::ST_ROUND) begin
            lfsr_ff <= lfsr_nx;
         end
         if (state_ff == mrpt_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (state_ff == mrpt_pkg::ST_DONE && out_free) begin
         rsp_data_ff <= {{(mrpt_pkg::RspDataBits - W - 1){1'b0}}, prime_ff, n_ff};
      end

      case (state_ff)
         mrpt_pkg::ST_IDLE:
            if (accept) begin
               n_ff     <= n_new;
               d_ff     <= n_new - W'(1);
               s_ff     <= '0;
               r_ff     <= '0;
               prime_ff <= (n_new >= W'(2)) && ((n_new <= W'(3)) || n_new[0]);
               if (rounds_ff == '0) begin
                  k_ff <= R'(1);
               end else if (rounds_ff > mrpt_pkg::RoundsMax) begin
                  k_ff <= mrpt_pkg::RoundsMax;
               end else begin
                  k_ff <= rounds_ff;
               end
            end
         mrpt_pkg::ST_SPLIT:
            if (!d_ff[0]) begin
               d_ff <= {1'b0, d_ff[W-1:1]};
               s_ff <= s_ff + R'(1);
            end
         mrpt_pkg::ST_BASE_WAIT:
            if (mm_done) begin
               sq_ff  <= mm_res + W'(2);
               acc_ff <= W'(1);
               e_ff   <= d_ff;
            end
         mrpt_pkg::ST_ACC_MUL:
            if (mm_done) begin
               acc_ff <= mm_res;
            end
         mrpt_pkg::ST_SQ_MUL:
            if (mm_done) begin
               sq_ff <= mm_res;
               e_ff  <= {1'b0, e_ff[W-1:1]};
            end
         mrpt_pkg::ST_CHECK:
            if (chk_pass) begin
               r_ff <= r_ff + R'(1);
            end else begin
               i_ff <= R'(1);
            end
         mrpt_pkg::ST_SQR:
            if (i_ff >= s_ff) begin
               prime_ff <= 1'b0;
            end
         mrpt_pkg::ST_X_MUL:
            if (mm_done) begin
               acc_ff <= mm_res;
               if (x_pass) begin
                  r_ff <= r_ff + R'(1);
               end else if (x_fail) begin
                  prime_ff <= 1'b0;
               end else begin
                  i_ff <= i_ff + R'(1);
               end
            end
         default: begin
         end
      endcase
   end

   // LFSR can never reach the all-zero lockup state
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0) else $error("lfsr reached zero");

   // multiplier only reports while the sequencer waits on it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (state_ff == mrpt_pkg::ST_BASE_WAIT || state_ff == mrpt_pkg::ST_ACC_MUL ||
                   state_ff == mrpt_pkg::ST_SQ_MUL || state_ff == mrpt_pkg::ST_X_MUL))
      else $error("multiplier done outside wait state");

   // residues stay reduced
   a_sq_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrpt_pkg::ST_POW) |-> (sq_ff < n_ff && acc_ff < n_ff))
      else $error("unreduced residue");

   // a result is only produced from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == mrpt_pkg::ST_DONE)
      else $error("result without done");

endmodule

>>> hw/rtl/mrpt_modmul.sv
`timescale 1ns / 1ps
// Interleaved modular multiply: one bit of b per cycle, MSB first.
// Needs a <= m, result = a*b mod m.
module mrpt_modmul (
   input  logic                            clock,
   input  logic                            reset,
   input  mrpt_pkg::mm_req_type            req,
   output logic                            done,
   output logic [mrpt_pkg::WordBits-1:0]   result
);

   localparam int W = mrpt_pkg::WordBits;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mrpt_pkg::MulCntBits-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                      acc_ff, acc_in;
   logic [W-1:0]                      a_ff, a_in;
   logic [W-1:0]                      b_ff, b_in;
   logic [W-1:0]                      m_ff, m_in;
   logic [W+1:0]                      t, m1, m2, red;

   always_comb begin
      t   = {1'b0, acc_ff, 1'b0} + (b_ff[W-1] ? {2'b00, a_ff} : '0);
      m1  = {2'b00, m_ff};
      m2  = {1'b0, m_ff, 1'b0};
      if (t >= m2) begin
         red = t - m2;
      end else if (t >= m1) begin
         red = t - m1;
      end else begin
         red = t;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (busy_ff) begin
         acc_in = red[W-1:0];
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + mrpt_pkg::MulCntBits'(1);
         if (cnt_ff == mrpt_pkg::MulCntBits'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
         m_in    = req.m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

>>> bench/miller_rabin_prime_test_test.sv
`timescale 1ns / 1ps
module miller_rabin_prime_test_test;

   localparam int CycleLimit = 40_000_000;

   typedef struct packed {
      logic [31:0] tested_number;
      logic        probably_prime;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [mrpt_pkg::RspDataBits-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mrpt_pkg::RoundsBits-1:0] csr_data = '0;

   // predictor state
   logic [31:0] model_lfsr;
   logic [mrpt_pkg::RoundsBits-1:0] model_rounds;
   verdict_type pending_verdicts[$];
   int errors = 0;
   int cycles = 0;
   bit stall_enable = 1'b1;

   miller_rabin_prime_test dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("miller_rabin_prime_test test failed");
         $finish;
      end
   end

   function automatic logic [31:0] mod_mul(logic [31:0] a, logic [31:0] b, logic [31:0] m);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return 32'(p % {32'd0, m});
   endfunction

   function automatic logic [31:0] mod_pow(logic [31:0] b, logic [31:0] e, logic [31:0] m);
      logic [31:0] acc;
      logic [31:0] sq;
      acc = 32'd1 % m;
      sq = b % m;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, sq, m);
         e = e >> 1;
         sq = mod_mul(sq, sq, m);
      end
      return acc;
   endfunction

   // one witness round; advances the predictor LFSR
   function automatic bit survives_round(logic [31:0] n, logic [31:0] d, int s);
      logic [31:0] base;
      logic [31:0] x;
      logic [31:0] sh;
      sh = {1'b0, model_lfsr[31:1]};
      model_lfsr = model_lfsr[0] ? (sh ^ 32'h8020_0003) : sh;
      base = 32'd2 + model_lfsr % (n - 32'd4);
      x = mod_pow(base, d, n);
      if (x == 32'd1 || x == n - 32'd1) return 1'b1;
      for (int i = 1; i < s; i++) begin
         x = mod_mul(x, x, n);
         if (x == n - 32'd1) return 1'b1;
         if (x == 32'd1) return 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type predict_primality(logic [31:0] raw);
      verdict_type v;
      logic [31:0] n;
      logic [31:0] d;
      int s;
      int k;
      n = raw & mrpt_pkg::NumberMask;
      k = model_rounds;
      if (k == 0) k = 1;
      if (k > 32) k = 32;
      v.tested_number = n;
      v.probably_prime = 1'b1;
      if (n < 2) v.probably_prime = 1'b0;
      else if (n <= 3) v.probably_prime = 1'b1;
      else if (!n[0]) v.probably_prime = 1'b0;
      else begin
         d = n - 1;
         s = 0;
         while (!d[0]) begin
            d = d >> 1;
            s++;
         end
         for (int r = 0; r < k; r++) begin
            if (!survives_round(n, d, s)) begin
               v.probably_prime = 1'b0;
               break;
            end
         end
      end
      return v;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // leaves req_tvalid high at the falling edge after the accept; a drain, or a
   // next send that waits a gap first, drops it
   task automatic send_number(logic [31:0] n);
      int g;
      g = stall_enable ? gap_len() : 0;
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tdata <= n;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(predict_primality(n));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_rounds(logic [mrpt_pkg::RoundsBits-1:0] r);
      drain();
      csr_data <= r;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_rounds = r;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: random stalls while stall_enable is set, checks each beat against the oldest prediction
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= stall_enable ? (gap_len() == 0 || $urandom_range(0, 1)) : 1'b1;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[31:0] !== want.tested_number) begin
               $error("tested_number expected %h got %h", want.tested_number,
                      rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[32] !== want.probably_prime) begin
               $error("probably_prime expected %b got %b", want.probably_prime,
                      rsp_tdata[32]);
               errors++;
            end
         end
      end
   end

   task automatic test_small_and_even();
      send_number(32'd0);
      send_number(32'd1);
      send_number(32'd2);
      send_number(32'd3);
      send_number(32'd4);
      send_number(32'hFFFF_FFFE);
      send_number(32'h8000_0000);
   endtask

   // reset rounds value, known primes and composites including strong pseudoprimes
   task automatic test_known_values();
      send_number(32'd5);
      send_number(32'd7);
      send_number(32'd9);
      send_number(32'd2047);          // strong pseudoprime to base 2
      send_number(32'd561);           // Carmichael
      send_number(32'd65537);
      send_number(32'hFFFF_FFFB);     // largest 32-bit prime
      send_number(32'hFFFF_FFFF);
      send_number(32'd97);            // s large enough for the squaring loop
   endtask

   // rounds extremes: zero behaves as one, above 32 saturates
   task automatic test_round_settings();
      write_rounds(6'd0);
      send_number(32'd2047);
      send_number(32'd1_000_003);
      write_rounds(6'd1);
      send_number(32'd3215031751);
      write_rounds(6'd63);
      send_number(32'd104_729);
      send_number(32'd25);
      write_rounds(6'd32);
      send_number(32'd7919);
   endtask

   task automatic test_pause_until_empty();
      send_number(32'd13);
      drain();
      send_number(32'd15);
   endtask

   task automatic random_number();
      logic [31:0] n;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) n = $urandom_range(0, 2000);
      else if (pick < 7) n = $urandom | 32'd1;
      else n = $urandom;
      send_number(n);
   endtask

   task automatic test_random();
      logic [mrpt_pkg::RoundsBits-1:0] setting;
      for (int phase = 0; phase < 6; phase++) begin
         setting = (phase == 0) ? 6'd1 : (phase == 1) ? 6'd40 :
                   mrpt_pkg::RoundsBits'($urandom);
         write_rounds(setting);
         stall_enable = (phase != 3);
         for (int i = 0; i < 45; i++) random_number();
      end
      stall_enable = 1'b1;
   endtask

   initial begin
      model_rounds = mrpt_pkg::RoundsReset;
      model_lfsr = mrpt_pkg::LfsrSeed;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_small_and_even();
      test_known_values();
      test_pause_until_empty();
      test_round_settings();
      test_random();
      drain();
      repeat (50) @(negedge clock);
      if (errors == 0 && pending_verdicts.size() == 0)
         $display("miller_rabin_prime_test test passed");
      else
         $display("miller_rabin_prime_test test failed");
      $finish;
   end

endmodule
